@@ rtl/core/dcs_pkg.sv @@
// Shared types and constants for the divisor count and sum block.
package dcs_pkg;

  // Output field widths and their saturation limits
  localparam int COUNT_W = 8;
  localparam int SUM_W   = 18;
  localparam int RATIO_W = 22;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
  localparam logic [RATIO_W-1:0] RATIO_MAX = '1;

  // Trial division candidates: the even prime, the first odd candidate, the odd step
  localparam int P_FIRST = 2;
  localparam int P_ODD   = 3;
  localparam int P_STEP  = 2;

  // Operation of the shared arithmetic unit
  typedef enum logic {
    OP_DIV,
    OP_MUL
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_ctl_t;

endpackage

@@ rtl/core/dcs_in_if.sv @@
// Input channel: one integer word per handshake.
interface dcs_in_if #(
  parameter int N_BITS = 16
) ();
  logic              valid;
  logic              ready;
  logic [N_BITS-1:0] n;

  modport source (output valid, output n, input ready);
  modport sink   (input valid, input n, output ready);
endinterface

@@ rtl/core/dcs_out_if.sv @@
// Result channel: divisor count, divisor sum, mean divisor and invalid flag.
interface dcs_out_if ();
  logic                        valid;
  logic                        ready;
  logic [dcs_pkg::COUNT_W-1:0] divisor_count;
  logic [dcs_pkg::SUM_W-1:0]   divisor_sum;
  logic [dcs_pkg::RATIO_W-1:0] ratio_hundredths;
  logic                        invalid;

  modport source (
    output valid, output divisor_count, output divisor_sum,
    output ratio_hundredths, output invalid, input ready
  );
  modport sink (
    input valid, input divisor_count, input divisor_sum,
    input ratio_hundredths, input invalid, output ready
  );
endinterface

@@ rtl/core/dcs_unit.sv @@
// Shared bit-serial unit: restoring divide or shift-add multiply, one bit a cycle.
module dcs_unit #(
  parameter int UW = 28
) (
  input  logic               clk,
  input  logic               rst,
  input  dcs_pkg::unit_ctl_t ctl,
  input  logic [UW-1:0]      a,
  input  logic [UW-1:0]      b,
  output logic               done,
  output logic [UW-1:0]      q,
  output logic [UW-1:0]      r
);
  import dcs_pkg::*;

  localparam int CW = $clog2(UW);

  logic          running;
  logic [CW-1:0] cnt;
  unit_op_t      op;
  logic [UW-1:0] acc;
  logic [UW-1:0] quo;
  logic [UW-1:0] mcand;
  logic [UW:0]   x;
  logic [UW+1:0] y_in;
  logic [UW+1:0] sum;
  logic          sub;

  // One adder serves both operations: subtract for divide, add for multiply
  always_comb begin
    sub  = 1'b0;
    x    = {1'b0, acc};
    y_in = {2'b00, mcand};
    unique case (op)
      OP_DIV: begin
        sub  = 1'b1;
        x    = {acc, quo[UW-1]};
        y_in = ~{2'b00, mcand};
      end
      OP_MUL: begin
        sub  = 1'b0;
        x    = {1'b0, acc};
        y_in = {2'b00, mcand};
      end
      default: ;
    endcase
    sum = {1'b0, x} + y_in + (UW+2)'(sub);
  end

  // Sequence the steps and flag the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(UW - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Load operands, then shift one bit a cycle
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      op  <= ctl.op;
      acc <= '0;
      if (ctl.op == OP_DIV) begin
        quo   <= a;
        mcand <= b;
      end else begin
        quo   <= b;
        mcand <= a;
      end
    end else if (running) begin
      unique case (op)
        OP_DIV: begin
          if (!sum[UW+1]) begin
            acc <= sum[UW-1:0];
            quo <= {quo[UW-2:0], 1'b1};
          end else begin
            acc <= x[UW-1:0];
            quo <= {quo[UW-2:0], 1'b0};
          end
        end
        OP_MUL: begin
          if (quo[0]) begin
            acc <= sum[UW-1:0];
          end
          mcand <= mcand << 1;
          quo   <= quo >> 1;
        end
        default: ;
      endcase
    end
  end

  assign q = (op == OP_DIV) ? quo : acc;
  assign r = acc;

endmodule

@@ rtl/core/dcs_seq.sv @@
// Sequencer: trial division, prime stripping and the final ratio on the shared unit.
module dcs_seq #(
  parameter int N_BITS = 16,
  parameter int UW     = 28
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [N_BITS-1:0]   n,
  output logic                res_valid,
  input  logic                res_take,
  output logic [N_BITS-1:0]   res_tau,
  output logic [N_BITS+3:0]   res_sigma,
  output logic [N_BITS+10:0]  res_ratio,
  output logic                res_inv,
  output dcs_pkg::unit_ctl_t  uctl,
  output logic [UW-1:0]       ua,
  output logic [UW-1:0]       ub,
  input  logic                udone,
  input  logic [UW-1:0]       uq,
  input  logic [UW-1:0]       ur
);
  import dcs_pkg::*;

  localparam int SW = N_BITS + 4;   // divisor sum
  localparam int RW = N_BITS + 11;  // ratio in hundredths
  localparam int PW = N_BITS + 2;   // square of the candidate

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_DIV_W, S_TERM, S_TERM_W, S_SIG, S_SIG_W,
    S_NEXT, S_CHECK, S_TAIL, S_TAIL_W, S_RATIO, S_RATIO_W, S_PUT
  } state_t;

  state_t            state;
  logic [N_BITS-1:0] rem;
  logic [N_BITS-1:0] p;
  logic [PW-1:0]     psq;
  logic [N_BITS-1:0] tau;
  logic [N_BITS-1:0] tau_base;
  logic [SW-1:0]     term;
  logic [SW-1:0]     sigma;
  logic [RW-1:0]     ratio;
  logic              inv;
  logic              inprime;
  logic [UW-1:0]     sig_w;
  logic [UW-1:0]     num;

  // 200*sigma + tau as shifts, over 2*tau gives the rounded hundredths
  assign sig_w = UW'(sigma);
  assign num   = (sig_w << 7) + (sig_w << 6) + (sig_w << 3) + UW'(tau);

  // Drive the shared unit
  always_comb begin
    uctl = '{start: 1'b0, op: OP_MUL};
    ua   = '0;
    ub   = '0;
    unique case (state)
      S_DIV: begin
        uctl = '{start: 1'b1, op: OP_DIV};
        ua   = UW'(rem);
        ub   = UW'(p);
      end
      S_TERM: begin
        uctl = '{start: 1'b1, op: OP_MUL};
        ua   = UW'(term);
        ub   = UW'(p);
      end
      S_SIG: begin
        uctl = '{start: 1'b1, op: OP_MUL};
        ua   = UW'(sigma);
        ub   = UW'(term);
      end
      S_TAIL: begin
        uctl = '{start: (rem > N_BITS'(1)), op: OP_MUL};
        ua   = UW'(sigma);
        ub   = UW'(rem) + UW'(1);
      end
      S_RATIO: begin
        uctl = '{start: 1'b1, op: OP_DIV};
        ua   = num;
        ub   = UW'(tau) << 1;
      end
      default: ;
    endcase
  end

  // Main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      inprime <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (n == '0) begin
              inv   <= 1'b1;
              tau   <= '0;
              sigma <= '0;
              ratio <= '0;
              state <= S_PUT;
            end else begin
              inv     <= 1'b0;
              rem     <= n;
              p       <= N_BITS'(P_FIRST);
              psq     <= PW'(P_FIRST * P_FIRST);
              tau     <= N_BITS'(1);
              sigma   <= SW'(1);
              inprime <= 1'b0;
              state   <= S_DIV;
            end
          end
        end
        S_DIV: state <= S_DIV_W;
        S_DIV_W: begin
          if (udone) begin
            if (ur == '0) begin
              // Candidate divides: strip it and grow count by the base
              rem     <= uq[N_BITS-1:0];
              tau     <= tau + (inprime ? tau_base : tau);
              if (!inprime) begin
                tau_base <= tau;
                term     <= SW'(1);
              end
              inprime <= 1'b1;
              state   <= S_TERM;
            end else if (inprime) begin
              state <= S_SIG;
            end else begin
              state <= S_NEXT;
            end
          end
        end
        S_TERM: state <= S_TERM_W;
        S_TERM_W: begin
          // term becomes 1 + p*term
          if (udone) begin
            term  <= uq[SW-1:0] + SW'(1);
            state <= S_DIV;
          end
        end
        S_SIG: state <= S_SIG_W;
        S_SIG_W: begin
          if (udone) begin
            sigma   <= uq[SW-1:0];
            inprime <= 1'b0;
            state   <= S_NEXT;
          end
        end
        S_NEXT: begin
          // Advance candidate and keep its square by (p+2)^2 = p^2 + 4p + 4
          if (p == N_BITS'(P_FIRST)) begin
            p   <= N_BITS'(P_ODD);
            psq <= PW'(P_ODD * P_ODD);
          end else begin
            p   <= p + N_BITS'(P_STEP);
            psq <= psq + (PW'(p) << 2) + PW'(P_STEP * P_STEP);
          end
          state <= S_CHECK;
        end
        S_CHECK: state <= (psq <= PW'(rem)) ? S_DIV : S_TAIL;
        S_TAIL: begin
          // Leftover cofactor above one is prime
          if (rem > N_BITS'(1)) begin
            tau   <= tau << 1;
            state <= S_TAIL_W;
          end else begin
            state <= S_RATIO;
          end
        end
        S_TAIL_W: begin
          if (udone) begin
            sigma <= uq[SW-1:0];
            state <= S_RATIO;
          end
        end
        S_RATIO: state <= S_RATIO_W;
        S_RATIO_W: begin
          if (udone) begin
            ratio <= uq[RW-1:0];
            state <= S_PUT;
          end
        end
        S_PUT: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_PUT);
  assign res_tau   = tau;
  assign res_sigma = sigma;
  assign res_ratio = ratio;
  assign res_inv   = inv;

endmodule

@@ rtl/core/divisor_count_and_sum.sv @@
// Divisor count and sum: takes one integer word, returns tau, sigma and sigma/tau.
//
// Input channel item carries n (N_BITS bits); result channel carries the divisor
// count, the divisor sum, their ratio in hundredths rounded half up, and an
// invalid flag that is set (with all other fields zero) for n of zero.
// Both channels move a word when valid and ready are high at a rising edge.
// One item is worked at a time: item.ready is high only while the sequencer
// is idle. Trial division runs on one bit-serial unit of UW = N_BITS+12 bits,
// shared by every division and multiplication. Each candidate tried costs its
// division plus advancing p and comparing p*p; each further division and
// Horner step on a found factor, each sigma update, the leftover-prime multiply
// and the final ratio each cost one more operation on the unit. Up to about
// 2^(N_BITS/2-1) candidates are tried; the longest inputs are a large prime,
// or the square of one.
// A finished result sits in the output register; while the receiver stalls
// the block still takes and works the next word, then holds its result until
// the register frees. Synchronous reset returns the block to idle and drops
// any word in flight and any pending result.
module divisor_count_and_sum #(
  parameter int N_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  dcs_in_if.sink    item,
  dcs_out_if.source result
);
  import dcs_pkg::*;

  localparam int UW = N_BITS + 12;
  localparam int XW = (UW > RATIO_W) ? UW : RATIO_W;

  unit_ctl_t          uctl;
  logic [UW-1:0]      ua;
  logic [UW-1:0]      ub;
  logic               udone;
  logic [UW-1:0]      uq;
  logic [UW-1:0]      ur;
  logic               res_valid;
  logic               res_take;
  logic               load;
  logic [N_BITS-1:0]  res_tau;
  logic [N_BITS+3:0]  res_sigma;
  logic [N_BITS+10:0] res_ratio;
  logic               res_inv;

  dcs_seq #(
    .N_BITS (N_BITS),
    .UW     (UW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .n         (item.n),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res_tau   (res_tau),
    .res_sigma (res_sigma),
    .res_ratio (res_ratio),
    .res_inv   (res_inv),
    .uctl      (uctl),
    .ua        (ua),
    .ub        (ub),
    .udone     (udone),
    .uq        (uq),
    .ur        (ur)
  );

  dcs_unit #(
    .UW (UW)
  ) u_unit (
    .clk  (clk),
    .rst  (rst),
    .ctl  (uctl),
    .a    (ua),
    .b    (ub),
    .done (udone),
    .q    (uq),
    .r    (ur)
  );

  assign res_take = !result.valid || result.ready;
  assign load     = res_valid && res_take;

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  // Saturate each field to its width and load the output register
  always_ff @(posedge clk) begin
    if (load) begin
      result.divisor_count    <= (XW'(res_tau) > XW'(COUNT_MAX)) ? COUNT_MAX
                                                                  : COUNT_W'(res_tau);
      result.divisor_sum      <= (XW'(res_sigma) > XW'(SUM_MAX)) ? SUM_MAX
                                                                  : SUM_W'(res_sigma);
      result.ratio_hundredths <= (XW'(res_ratio) > XW'(RATIO_MAX)) ? RATIO_MAX
                                                                    : RATIO_W'(res_ratio);
      result.invalid          <= res_inv;
    end
  end

`ifndef ASSERT_OFF
  // An invalid result carries zero in every other field
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.invalid |->
      result.divisor_count == '0 && result.divisor_sum == '0 &&
      result.ratio_hundredths == '0)
    else $error("invalid result with non-zero fields");

  // The block is busy in the cycle after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> !item.ready)
    else $error("input ready straight after accepting a word");

  // A valid input always has at least one divisor and a non-zero mean
  a_valid_nonzero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.invalid |->
      result.divisor_count != '0 && result.ratio_hundredths != '0)
    else $error("zero count or ratio on a valid result");
`endif

endmodule

@@ bench/divisor_count_and_sum_tb.sv @@
// Self-checking testbench for the divisor count and sum block.
`timescale 1ns / 1ps

module divisor_count_and_sum_tb;
  import dcs_pkg::*;

  localparam int N_BITS       = 16;
  localparam int HOLD_CYCLES  = 4000;
  localparam int STALL_LIMIT  = 40000;
  localparam int SETTLE_TICKS = 200;

  // Edge values: zero, one, prime powers, squares near the top, smooth and prime words
  localparam logic [N_BITS-1:0] CORNER_WORDS [23] = '{
    16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd6, 16'd9, 16'd25, 16'd49, 16'd961,
    16'd63001, 16'd64009, 16'd65025, 16'd32768, 16'd59049, 16'd55440, 16'd45045,
    16'd30030, 16'd65521, 16'd65534, 16'd65535, 16'd21845, 16'd43690
  };

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   sum;
    logic [RATIO_W-1:0] ratio;
    logic               invalid;
  } divisor_result_t;

  logic clk = 1'b0;
  logic rst;

  dcs_in_if #(.N_BITS(N_BITS)) item_ch ();
  dcs_out_if                   result_ch ();

  divisor_count_and_sum #(.N_BITS(N_BITS)) u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  divisor_result_t expected_results[$];
  int unsigned     mismatches = 0;
  int unsigned     idle_cycles = 0;
  int unsigned     hold_requests = 0;
  bit              rx_stall_on = 1'b0;
  int unsigned     gap_max = 0;
  int unsigned     burst_left = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Work out tau, sigma and the rounded mean divisor by trial division
  function automatic divisor_result_t predict_divisors(input logic [N_BITS-1:0] value);
    longint unsigned rem, p, term, pw, tau, sigma, ratio;
    longint unsigned a;
    divisor_result_t r;
    r = '0;
    if (value == '0) begin
      r.invalid = 1'b1;
      return r;
    end
    rem   = value;
    tau   = 1;
    sigma = 1;
    p     = P_FIRST;
    while (p * p <= rem) begin
      if (rem % p == 0) begin
        term = 1;
        pw   = 1;
        a    = 0;
        while (rem % p == 0) begin
          rem  = rem / p;
          pw   = pw * p;
          term = term + pw;
          a++;
        end
        tau   = tau * (a + 1);
        sigma = sigma * term;
      end
      p = (p == P_FIRST) ? P_ODD : p + P_STEP;
    end
    // Leftover cofactor above one is a prime of its own
    if (rem > 1) begin
      tau   = tau * 2;
      sigma = sigma * (rem + 1);
    end
    ratio     = (200 * sigma + tau) / (2 * tau);
    r.count   = (tau > COUNT_MAX) ? COUNT_MAX : tau[COUNT_W-1:0];
    r.sum     = (sigma > SUM_MAX) ? SUM_MAX : sigma[SUM_W-1:0];
    r.ratio   = (ratio > RATIO_MAX) ? RATIO_MAX : ratio[RATIO_W-1:0];
    r.invalid = 1'b0;
    return r;
  endfunction

  // Predict a result for every accepted word
  always @(posedge clk) begin
    if (!rst && item_ch.valid && item_ch.ready)
      expected_results.push_back(predict_divisors(item_ch.n));
  end

  // Compare each delivered result with the oldest prediction
  always @(posedge clk) begin
    divisor_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result word with no prediction pending: count %0d sum %0d",
               result_ch.divisor_count, result_ch.divisor_sum);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (result_ch.divisor_count !== want.count) begin
          $error("divisor_count: expected %0d, got %0d", want.count, result_ch.divisor_count);
          mismatches++;
        end
        if (result_ch.divisor_sum !== want.sum) begin
          $error("divisor_sum: expected %0d, got %0d", want.sum, result_ch.divisor_sum);
          mismatches++;
        end
        if (result_ch.ratio_hundredths !== want.ratio) begin
          $error("ratio_hundredths: expected %0d, got %0d", want.ratio,
                 result_ch.ratio_hundredths);
          mismatches++;
        end
        if (result_ch.invalid !== want.invalid) begin
          $error("invalid: expected %0d, got %0d", want.invalid, result_ch.invalid);
          mismatches++;
        end
      end
    end
  end

  // Abort when no word moves on either channel for too long
  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("divisor_count_and_sum verification failed");
      $finish;
    end
  end

  // Receiver: random eight-bit stall mask refreshed once its bits are used up, long hold on request
  initial begin
    int unsigned hold_left;
    int unsigned holds_seen;
    logic [7:0]  stall_mask;
    int unsigned phase;
    hold_left       = 0;
    holds_seen      = 0;
    stall_mask      = '1;
    phase           = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (phase == 0)
        stall_mask = rx_stall_on ? 8'($urandom | $urandom) : 8'hFF;
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= stall_mask[phase];
      end
      phase = (phase == 7) ? 0 : phase + 1;
    end
  end

  // Offer one word, hold it until taken, then idle between bursts
  task automatic send_word(input logic [N_BITS-1:0] value);
    int unsigned gap;
    @(negedge clk);
    item_ch.valid <= 1'b1;
    item_ch.n     <= value;
    do @(posedge clk); while (!item_ch.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(12, 1);
      gap = (gap_max > 0) ? $urandom_range(gap_max, 0) : 0;
      if (gap > 0) begin
        @(negedge clk);
        item_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic wait_drained();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_corners();
    gap_max     = 0;
    rx_stall_on = 1'b0;
    foreach (CORNER_WORDS[i]) send_word(CORNER_WORDS[i]);
    wait_drained();
  endtask

  task automatic test_full_range(input int unsigned count);
    gap_max     = 20;
    rx_stall_on = 1'b1;
    repeat (count) send_word(N_BITS'($urandom));
    wait_drained();
  endtask

  // Mostly short factorisations, with the odd zero
  task automatic test_small_values(input int unsigned count);
    gap_max     = 6;
    rx_stall_on = 1'b1;
    repeat (count) begin
      if ($urandom_range(24, 0) == 0)
        send_word('0);
      else
        send_word(N_BITS'($urandom_range(4095, 1)));
    end
    wait_drained();
  endtask

  // Products of small primes: many factors, large tau and sigma
  task automatic test_smooth_values(input int unsigned count);
    int unsigned word;
    int unsigned factor;
    gap_max     = 3;
    rx_stall_on = 1'b1;
    repeat (count) begin
      word = 1;
      repeat (20) begin
        case ($urandom_range(5, 0))
          0: factor = 2;
          1: factor = 3;
          2: factor = 5;
          3: factor = 7;
          4: factor = 11;
          default: factor = 13;
        endcase
        if (word * factor <= 65535) word = word * factor;
      end
      send_word(N_BITS'(word));
    end
    wait_drained();
  endtask

  // Hold the result side off while words keep coming, so the block backs up
  task automatic test_result_backpressure();
    gap_max     = 0;
    rx_stall_on = 1'b0;
    hold_requests++;
    send_word(16'd12);
    send_word(16'd360);
    send_word(16'd97);
    send_word(16'd1001);
    send_word(16'd2310);
    wait_drained();
  endtask

  // Short batches with the sender paused until each batch has drained
  task automatic test_paused_batches(input int unsigned batches);
    gap_max     = 4;
    rx_stall_on = 1'b1;
    repeat (batches) begin
      repeat ($urandom_range(3, 1)) begin
        if ($urandom_range(3, 0) == 0)
          send_word(N_BITS'($urandom));
        else
          send_word(N_BITS'($urandom_range(1023, 0)));
      end
      wait_drained();
    end
  endtask

  initial begin
    rst           = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.n     = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_corners();
    test_small_values(40);
    test_full_range(40);
    test_smooth_values(20);
    test_result_backpressure();
    test_paused_batches(6);

    wait_drained();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (expected_results.size() != 0)
      $error("%0d predicted results never arrived", expected_results.size());
    if (mismatches == 0 && expected_results.size() == 0)
      $display("divisor_count_and_sum verification clean");
    else
      $display("divisor_count_and_sum verification failed");
    $finish;
  end

endmodule
